// ===== src/blr_pkg.sv =====
// Shared types and constants for the line rasterizer.
package blr_pkg;

   localparam int DIM_BITS   = 13;
   localparam int COLOR_BITS = 32;
   localparam int CSR_ADDR_BITS = 1;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RST  = 13'd640;
   localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RST = 13'd480;

   typedef struct packed {
      logic y_is_major;
      logic minor_up;
      logic busy;
   } blr_ctrl_type;

endpackage

// ===== src/blr_if.sv =====
// Channel interfaces: line command, pixel word and register write.
interface blr_req_if #(parameter int COORD_BITS = 16);
   logic                              valid;
   logic                              ready;
   logic                              cmd;
   logic signed [COORD_BITS-1:0]      x_start;
   logic signed [COORD_BITS-1:0]      y_start;
   logic signed [COORD_BITS-1:0]      x_end;
   logic signed [COORD_BITS-1:0]      y_end;
   logic [blr_pkg::COLOR_BITS-1:0]    color_in;

   modport source (output valid, cmd, x_start, y_start, x_end, y_end, color_in,
                   input ready);
   modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, color_in,
                   output ready);
endinterface

interface blr_rsp_if #(parameter int COORD_BITS = 16);
   logic                              valid;
   logic                              ready;
   logic signed [COORD_BITS-1:0]      pix_x;
   logic signed [COORD_BITS-1:0]      pix_y;
   logic [blr_pkg::COLOR_BITS-1:0]    pix_color;
   logic                              inside_res;
   logic                              last;

   modport source (output valid, pix_x, pix_y, pix_color, inside_res, last,
                   input ready);
   modport sink   (input valid, pix_x, pix_y, pix_color, inside_res, last,
                   output ready);
endinterface

interface blr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [blr_pkg::CSR_ADDR_BITS-1:0]   addr;
   logic [blr_pkg::DIM_BITS-1:0]        wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== src/bresenham_line_rasterizer.sv =====
// Top level of the line rasterizer: line state, pixel output register, registers.
//
//  channel  | dir | word                                          | taken when
//  ---------+-----+-----------------------------------------------+-------------------
//  req_ch   | in  | cmd, x_start, y_start, x_end, y_end, color_in | valid & ready
//  rsp_ch   | out | pix_x, pix_y, pix_color, inside_res, last     | valid & ready
//  csr_ch   | in  | addr, wdata (screen width / height)           | valid (ready = 1)
//
// One command word a cycle while the output is not stalled: the line state and the pixel
// register are both loaded at the edge that takes the word, so a step may follow a load in
// the next cycle. A pixel word shows in the cycle after its command is taken. The single pixel
// register sets the rate: a new command is taken when it is empty or being drained this cycle.
// A step with no line active is taken and gives no pixel word.
// Synchronous active-high reset clears line state, empties the pixel register and
// restores width 640 and height 480.
module bresenham_line_rasterizer #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   blr_req_if.sink                       req_ch,
   blr_rsp_if.source                     rsp_ch,
   blr_csr_if.sink                       csr_ch
);

   localparam int CB   = COORD_BITS;
   localparam int ERRW = CB + 3;

   // configuration
   logic [blr_pkg::DIM_BITS-1:0]   width_ff, height_ff;

   // line state
   logic [CB-1:0]                  cur_x_ff, cur_y_ff, major_end_ff;
   logic [ERRW-1:0]                err_ff;
   logic [CB:0]                    abs_dx_ff, abs_dy_ff;
   logic [blr_pkg::COLOR_BITS-1:0] color_ff;
   blr_pkg::blr_ctrl_type          ctrl_ff;

   // next state from the walker
   logic [CB-1:0]                  cur_x_in, cur_y_in, major_end_in;
   logic [ERRW-1:0]                err_in;
   logic [CB:0]                    abs_dx_in, abs_dy_in;
   blr_pkg::blr_ctrl_type          ctrl_in;
   logic                           update, inside_in;
   logic [blr_pkg::COLOR_BITS-1:0] color_in;

   // pixel output register
   logic                           rsp_valid_ff;
   logic [CB-1:0]                  pix_x_ff, pix_y_ff;
   logic [blr_pkg::COLOR_BITS-1:0] pix_color_ff;
   logic                           inside_ff, last_ff;

   logic                           req_take;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign color_in = (req_ch.cmd == blr_pkg::CMD_LOAD) ? req_ch.color_in : color_ff;

   blr_core #(.COORD_BITS(CB)) u_core (
      .cmd           (req_ch.cmd),
      .x_start       (req_ch.x_start),
      .y_start       (req_ch.y_start),
      .x_end         (req_ch.x_end),
      .y_end         (req_ch.y_end),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .cur_x         (cur_x_ff),
      .cur_y         (cur_y_ff),
      .major_end     (major_end_ff),
      .err_term      (err_ff),
      .abs_dx        (abs_dx_ff),
      .abs_dy        (abs_dy_ff),
      .ctrl          (ctrl_ff),
      .nxt_x         (cur_x_in),
      .nxt_y         (cur_y_in),
      .nxt_major_end (major_end_in),
      .nxt_err       (err_in),
      .nxt_abs_dx    (abs_dx_in),
      .nxt_abs_dy    (abs_dy_in),
      .nxt_ctrl      (ctrl_in),
      .update        (update),
      .nxt_inside    (inside_in)
   );

   // screen registers; an unknown address is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= blr_pkg::SCREEN_WIDTH_RST;
         height_ff <= blr_pkg::SCREEN_HEIGHT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            blr_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_ch.wdata;
            blr_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // line state moves only on a load or on a step of an active line
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         major_end_ff <= '0;
         err_ff       <= '0;
         abs_dx_ff    <= '0;
         abs_dy_ff    <= '0;
         color_ff     <= '0;
         ctrl_ff      <= '0;
      end else if (req_take && update) begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         major_end_ff <= major_end_in;
         err_ff       <= err_in;
         abs_dx_ff    <= abs_dx_in;
         abs_dy_ff    <= abs_dy_in;
         color_ff     <= color_in;
         ctrl_ff      <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= update;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && update) begin
         pix_x_ff     <= cur_x_in;
         pix_y_ff     <= cur_y_in;
         pix_color_ff <= color_in;
         inside_ff    <= inside_in;
         last_ff      <= !ctrl_in.busy;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pix_x      = pix_x_ff;
   assign rsp_ch.pix_y      = pix_y_ff;
   assign rsp_ch.pix_color  = pix_color_ff;
   assign rsp_ch.inside_res = inside_ff;
   assign rsp_ch.last       = last_ff;

endmodule

// ===== src/blr_core.sv =====
// Next-state logic for one load or step of the line walker.
module blr_core #(
   parameter int COORD_BITS = 16
) (
   input  logic                          cmd,
   input  logic [COORD_BITS-1:0]         x_start,
   input  logic [COORD_BITS-1:0]         y_start,
   input  logic [COORD_BITS-1:0]         x_end,
   input  logic [COORD_BITS-1:0]         y_end,
   input  logic [blr_pkg::DIM_BITS-1:0]  screen_width,
   input  logic [blr_pkg::DIM_BITS-1:0]  screen_height,
   input  logic [COORD_BITS-1:0]         cur_x,
   input  logic [COORD_BITS-1:0]         cur_y,
   input  logic [COORD_BITS-1:0]         major_end,
   input  logic [COORD_BITS+2:0]         err_term,
   input  logic [COORD_BITS:0]           abs_dx,
   input  logic [COORD_BITS:0]           abs_dy,
   input  blr_pkg::blr_ctrl_type         ctrl,
   output logic [COORD_BITS-1:0]         nxt_x,
   output logic [COORD_BITS-1:0]         nxt_y,
   output logic [COORD_BITS-1:0]         nxt_major_end,
   output logic [COORD_BITS+2:0]         nxt_err,
   output logic [COORD_BITS:0]           nxt_abs_dx,
   output logic [COORD_BITS:0]           nxt_abs_dy,
   output blr_pkg::blr_ctrl_type         nxt_ctrl,
   output logic                          update,
   output logic                          nxt_inside
);

   localparam int CB   = COORD_BITS;
   localparam int DB   = blr_pkg::DIM_BITS;
   localparam int CW   = ((CB > DB) ? CB : DB) + 1;
   localparam int ERRW = CB + 3;

   logic signed [CW-1:0] wid_s, hgt_s;
   logic [CB-1:0]        x1, y1, x2, y2;
   logic [CB:0]          dx, dy, ld_adx, ld_ady;
   logic                 ld_ymaj, ld_up, ld_busy, ld_swap;
   logic [ERRW-1:0]      ld_err;

   logic [ERRW-1:0]      tw_min, tw_maj, st_err;
   logic                 stay;
   logic [CB-1:0]        minor_step, st_x, st_y, st_major;
   logic                 st_busy;

   assign wid_s = signed'({{(CW-DB){1'b0}}, screen_width});
   assign hgt_s = signed'({{(CW-DB){1'b0}}, screen_height});

   // endpoints sitting on the far screen edge are pulled in by one
   assign x1 = (signed'({{(CW-CB){x_start[CB-1]}}, x_start}) == wid_s) ?
               x_start - CB'(1) : x_start;
   assign x2 = (signed'({{(CW-CB){x_end[CB-1]}}, x_end}) == wid_s) ?
               x_end - CB'(1) : x_end;
   assign y1 = (signed'({{(CW-CB){y_start[CB-1]}}, y_start}) == hgt_s) ?
               y_start - CB'(1) : y_start;
   assign y2 = (signed'({{(CW-CB){y_end[CB-1]}}, y_end}) == hgt_s) ?
               y_end - CB'(1) : y_end;

   assign dx = {x2[CB-1], x2} - {x1[CB-1], x1};
   assign dy = {y2[CB-1], y2} - {y1[CB-1], y1};
   assign ld_adx = dx[CB] ? (CB+1)'(0) - dx : dx;
   assign ld_ady = dy[CB] ? (CB+1)'(0) - dy : dy;
   assign ld_up  = (dx[CB] && dy[CB]) ||
                   (!dx[CB] && (dx != '0) && !dy[CB] && (dy != '0));
   assign ld_ymaj = ld_ady > ld_adx;
   assign ld_err  = ld_ymaj ? ({1'b0, ld_adx, 1'b0} - {2'b00, ld_ady})
                            : ({1'b0, ld_ady, 1'b0} - {2'b00, ld_adx});
   // start from the lower major end; a walk is left only if that end differs
   assign ld_swap = ld_ymaj ? dy[CB] : dx[CB];
   assign ld_busy = ld_ymaj ? (ld_ady != '0) : (ld_adx != '0);

   // one step along the major axis
   assign tw_min = ctrl.y_is_major ? {1'b0, abs_dx, 1'b0} : {1'b0, abs_dy, 1'b0};
   assign tw_maj = ctrl.y_is_major ? {1'b0, abs_dy, 1'b0} : {1'b0, abs_dx, 1'b0};
   assign stay   = ctrl.y_is_major ? (err_term[ERRW-1] || (err_term == '0))
                                   : err_term[ERRW-1];
   assign st_err = err_term + (stay ? tw_min : tw_min - tw_maj);
   assign minor_step = ctrl.minor_up ? CB'(1) : {CB{1'b1}};

   always_comb begin
      if (ctrl.y_is_major) begin
         st_y = cur_y + CB'(1);
         st_x = stay ? cur_x : cur_x + minor_step;
         st_major = st_y;
      end else begin
         st_x = cur_x + CB'(1);
         st_y = stay ? cur_y : cur_y + minor_step;
         st_major = st_x;
      end
   end

   assign st_busy = signed'(st_major) < signed'(major_end);

   always_comb begin
      if (cmd == blr_pkg::CMD_LOAD) begin
         update        = 1'b1;
         nxt_x         = ld_swap ? x2 : x1;
         nxt_y         = ld_swap ? y2 : y1;
         nxt_major_end = ld_ymaj ? (ld_swap ? y1 : y2) : (ld_swap ? x1 : x2);
         nxt_err       = ld_err;
         nxt_abs_dx    = ld_adx;
         nxt_abs_dy    = ld_ady;
         nxt_ctrl.y_is_major = ld_ymaj;
         nxt_ctrl.minor_up   = ld_up;
         nxt_ctrl.busy       = ld_busy;
      end else begin
         update        = ctrl.busy;
         nxt_x         = st_x;
         nxt_y         = st_y;
         nxt_major_end = major_end;
         nxt_err       = st_err;
         nxt_abs_dx    = abs_dx;
         nxt_abs_dy    = abs_dy;
         nxt_ctrl.y_is_major = ctrl.y_is_major;
         nxt_ctrl.minor_up   = ctrl.minor_up;
         nxt_ctrl.busy       = st_busy;
      end
   end

   // clip test on the pixel about to be shown
   assign nxt_inside = !nxt_x[CB-1] && !nxt_y[CB-1] &&
                       (signed'({{(CW-CB){1'b0}}, nxt_x}) < wid_s) &&
                       (signed'({{(CW-CB){1'b0}}, nxt_y}) < hgt_s);

endmodule

// ===== src/blr_checker.sv =====
// Port-level checks for the line rasterizer, bound to the top level.
module blr_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_cmd,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [COORD_BITS-1:0]         pix_x,
   input logic [COORD_BITS-1:0]         pix_y,
   input logic                          inside_res
);

   // a load always yields a pixel word in the next cycle
   a_load_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == blr_pkg::CMD_LOAD) |=> rsp_valid)
      else $error("load gave no pixel word");

   // an empty output register never blocks the command side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("command stalled with empty output");

   // a pixel flagged inside has no negative coordinate
   a_inside_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && inside_res |-> !pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1])
      else $error("inside pixel with negative coordinate");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("pixel word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pix_x) && $stable(pix_y))
      else $error("pixel word changed while stalled");

endmodule

bind bresenham_line_rasterizer blr_checker #(.COORD_BITS(COORD_BITS)) u_blr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_cmd    (req_ch.cmd),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .pix_x      (rsp_ch.pix_x),
   .pix_y      (rsp_ch.pix_y),
   .inside_res (rsp_ch.inside_res)
);
